// ----- src/oprd_pkg.sv -----
// Shared types and constants for the 65816 operand and reference decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package oprd_pkg;

  localparam int ModeW = 5;
  localparam int AddrW = 24;
  localparam int RefW  = 25;
  localparam int WordW = 16;
  localparam int ByteW = 8;

  // queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int QCntW  = 2;

  // item function codes
  localparam logic FUNC_DECODE = 1'b0;
  localparam logic FUNC_REPLY  = 1'b1;

  // result kind codes
  localparam logic KIND_FETCH  = 1'b0;
  localparam logic KIND_RESULT = 1'b1;

  // addressing modes
  localparam logic [ModeW-1:0] MODE_IMPLIED   = 5'd0;
  localparam logic [ModeW-1:0] MODE_IMM_M     = 5'd1;
  localparam logic [ModeW-1:0] MODE_IMM_X     = 5'd2;
  localparam logic [ModeW-1:0] MODE_IMM8      = 5'd3;
  localparam logic [ModeW-1:0] MODE_REL       = 5'd4;
  localparam logic [ModeW-1:0] MODE_REL_LONG  = 5'd5;
  localparam logic [ModeW-1:0] MODE_DP        = 5'd6;
  localparam logic [ModeW-1:0] MODE_DP_X      = 5'd7;
  localparam logic [ModeW-1:0] MODE_DP_Y      = 5'd8;
  localparam logic [ModeW-1:0] MODE_DP_IND    = 5'd9;
  localparam logic [ModeW-1:0] MODE_DP_X_IND  = 5'd10;
  localparam logic [ModeW-1:0] MODE_DP_IND_Y  = 5'd11;
  localparam logic [ModeW-1:0] MODE_DP_LIND   = 5'd12;
  localparam logic [ModeW-1:0] MODE_DP_LIND_Y = 5'd13;
  localparam logic [ModeW-1:0] MODE_ABS       = 5'd14;
  localparam logic [ModeW-1:0] MODE_ABS_X     = 5'd15;
  localparam logic [ModeW-1:0] MODE_ABS_Y     = 5'd16;
  localparam logic [ModeW-1:0] MODE_LONG      = 5'd17;
  localparam logic [ModeW-1:0] MODE_LONG_X    = 5'd18;
  localparam logic [ModeW-1:0] MODE_SR_S      = 5'd19;
  localparam logic [ModeW-1:0] MODE_SR_S_IND_Y = 5'd20;
  localparam logic [ModeW-1:0] MODE_ABS_IND   = 5'd21;
  localparam logic [ModeW-1:0] MODE_ABS_LIND  = 5'd22;
  localparam logic [ModeW-1:0] MODE_ABS_X_IND = 5'd23;
  localparam logic [ModeW-1:0] MODE_ACC       = 5'd24;
  localparam logic [ModeW-1:0] MODE_BLOCK     = 5'd25;
  localparam logic [ModeW-1:0] MODE_PEA       = 5'd26;
  localparam logic [ModeW-1:0] MODE_PEI       = 5'd27;

  // classified item as it waits in the queue
  typedef struct packed {
    logic             func;
    logic [ModeW-1:0] mode;
    logic [AddrW-1:0] opv;
    logic             opok;
    logic [RefW-1:0]  dref;
    logic             dok;
    logic             indirect;
    logic [WordW-1:0] y;
    logic [ByteW-1:0] db;
    logic [ByteW-1:0] pb;
    logic [AddrW-1:0] rdata;
  } oprd_entry_t;

endpackage

`default_nettype wire

// ----- src/oprd_front.sv -----
// Front end: classifies one incoming transaction by addressing mode.
// Computes operand value and direct reference; depends on oprd_pkg.
`default_nettype none

module oprd_front (
  input  wire logic                      func,
  input  wire logic [oprd_pkg::ModeW-1:0] mode,
  input  wire logic [oprd_pkg::AddrW-1:0] pc,
  input  wire logic [oprd_pkg::AddrW-1:0] operand_bytes,
  input  wire logic [oprd_pkg::ByteW-1:0] status_flags,
  input  wire logic [oprd_pkg::WordW-1:0] direct_page,
  input  wire logic [oprd_pkg::WordW-1:0] index_x,
  input  wire logic [oprd_pkg::WordW-1:0] index_y,
  input  wire logic [oprd_pkg::WordW-1:0] stack_ptr,
  input  wire logic [oprd_pkg::ByteW-1:0] data_bank,
  input  wire logic [oprd_pkg::ByteW-1:0] program_bank,
  input  wire logic [oprd_pkg::AddrW-1:0] read_data,
  output oprd_pkg::oprd_entry_t           entry
);
  import oprd_pkg::*;

  logic [ByteW-1:0] b0;
  logic [WordW-1:0] w16;
  logic [RefW-1:0]  rel_ref;
  logic [RefW-1:0]  rel_long_ref;
  logic [RefW-1:0]  dp_ref;
  logic [RefW-1:0]  dp_x_ref;
  logic [RefW-1:0]  dp_y_ref;
  logic [RefW-1:0]  sr_ref;
  logic [AddrW-1:0] abs_x_sum;
  logic [AddrW-1:0] abs_y_sum;
  logic [WordW-1:0] w16_x;

  // address arithmetic shared by the mode arms
  assign b0           = operand_bytes[7:0];
  assign w16          = operand_bytes[15:0];
  assign rel_ref      = {9'd0, pc[15:0]} + 25'd2 + {{17{b0[7]}}, b0};
  assign rel_long_ref = {9'd0, pc[15:0]} + 25'd3 + {{9{w16[15]}}, w16};
  assign dp_ref       = {9'd0, direct_page} + {17'd0, b0};
  assign dp_x_ref     = dp_ref + {9'd0, index_x};
  assign dp_y_ref     = dp_ref + {9'd0, index_y};
  assign sr_ref       = {9'd0, stack_ptr} + {17'd0, b0};
  assign abs_x_sum    = {data_bank, w16} + {8'd0, index_x};
  assign abs_y_sum    = {data_bank, w16} + {8'd0, index_y};
  assign w16_x        = w16 + index_x;

  // per-mode classification
  always_comb begin
    entry          = '0;
    entry.func     = func;
    entry.mode     = mode;
    entry.y        = index_y;
    entry.db       = data_bank;
    entry.pb       = program_bank;
    entry.rdata    = read_data;
    entry.opok     = 1'b1;
    unique case (mode) inside
      MODE_IMM_M: begin
        entry.opv = status_flags[5] ? {16'd0, b0} : {8'd0, w16};
      end
      MODE_IMM_X: begin
        entry.opv = status_flags[4] ? {16'd0, b0} : {8'd0, w16};
      end
      MODE_IMM8, MODE_SR_S: begin
        entry.opv = {16'd0, b0};
      end
      MODE_REL: begin
        entry.opv  = {16'd0, b0};
        entry.dref = rel_ref;
        entry.dok  = 1'b1;
      end
      MODE_REL_LONG: begin
        entry.opv  = {8'd0, w16};
        entry.dref = rel_long_ref;
        entry.dok  = 1'b1;
      end
      MODE_DP, MODE_PEI: begin
        entry.opv  = {16'd0, b0};
        entry.dref = dp_ref;
        entry.dok  = 1'b1;
      end
      MODE_DP_X: begin
        entry.opv  = {16'd0, b0};
        entry.dref = dp_x_ref;
        entry.dok  = 1'b1;
      end
      MODE_DP_Y: begin
        entry.opv  = {16'd0, b0};
        entry.dref = dp_y_ref;
        entry.dok  = 1'b1;
      end
      MODE_DP_IND, MODE_DP_IND_Y, MODE_DP_LIND, MODE_DP_LIND_Y: begin
        entry.opv      = {16'd0, b0};
        entry.dref     = dp_ref;
        entry.dok      = 1'b1;
        entry.indirect = 1'b1;
      end
      MODE_DP_X_IND: begin
        entry.opv      = {16'd0, b0};
        entry.dref     = dp_x_ref;
        entry.dok      = 1'b1;
        entry.indirect = 1'b1;
      end
      MODE_ABS: begin
        entry.opv  = {8'd0, w16};
        entry.dref = {1'b0, data_bank, w16};
        entry.dok  = 1'b1;
      end
      MODE_ABS_X: begin
        entry.opv  = {8'd0, w16};
        entry.dref = {1'b0, abs_x_sum};
        entry.dok  = 1'b1;
      end
      MODE_ABS_Y: begin
        entry.opv  = {8'd0, w16};
        entry.dref = {1'b0, abs_y_sum};
        entry.dok  = 1'b1;
      end
      MODE_LONG: begin
        entry.opv  = operand_bytes;
        entry.dref = {1'b0, operand_bytes};
        entry.dok  = 1'b1;
      end
      MODE_LONG_X: begin
        entry.opv  = operand_bytes;
        entry.dref = {1'b0, operand_bytes[23:16], w16_x};
        entry.dok  = 1'b1;
      end
      MODE_SR_S_IND_Y: begin
        entry.opv      = {16'd0, b0};
        entry.dref     = sr_ref;
        entry.indirect = 1'b1;
      end
      MODE_ABS_IND, MODE_ABS_LIND: begin
        entry.opv      = {8'd0, w16};
        entry.dref     = {9'd0, w16};
        entry.dok      = 1'b1;
        entry.indirect = 1'b1;
      end
      MODE_ABS_X_IND: begin
        entry.opv      = {8'd0, w16};
        entry.dref     = {1'b0, program_bank, w16_x};
        entry.dok      = 1'b1;
        entry.indirect = 1'b1;
      end
      MODE_BLOCK, MODE_PEA: begin
        entry.opv = {8'd0, w16};
      end
      default: begin
        // implied, accumulator and unused codes carry nothing
        entry.opok = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/oprd_queue.sv -----
// Two-entry queue holding classified transactions between front and back.
// Depends on oprd_pkg for the entry type and depth constants.
`default_nettype none

module oprd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire oprd_pkg::oprd_entry_t push_entry,
  input  wire logic                 pop,
  output oprd_pkg::oprd_entry_t     head,
  output logic                      empty,
  output logic                      full
);
  import oprd_pkg::*;

  oprd_entry_t      slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;

  assign empty   = (count == QCntW'(0));
  assign full    = (count == QCntW'(QDepth));
  assign do_push = push && !full;
  assign head    = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      if (do_push && !pop) begin
        count <= count + QCntW'(1);
      end else if (pop && !do_push) begin
        count <= count - QCntW'(1);
      end
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("queue fill count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

// ----- src/oprd_back.sv -----
// Back end: keeps the pending pointer-fetch context and builds results.
// Owns the output register; depends on oprd_pkg.
`default_nettype none

module oprd_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire oprd_pkg::oprd_entry_t      head,
  input  wire logic                       empty,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            kind,
  output logic [oprd_pkg::AddrW-1:0]      fetch_address,
  output logic [oprd_pkg::AddrW-1:0]      operand_value,
  output logic                            operand_valid,
  output logic [oprd_pkg::RefW-1:0]       direct_target,
  output logic                            direct_valid,
  output logic [oprd_pkg::AddrW-1:0]      indirect_target,
  output logic                            indirect_valid
);
  import oprd_pkg::*;

  // pending context
  logic             pending;
  logic [ModeW-1:0] pending_mode;
  logic [AddrW-1:0] saved_operand;
  logic [RefW-1:0]  saved_reference;
  logic [WordW-1:0] saved_y;
  logic [ByteW-1:0] saved_db;
  logic [ByteW-1:0] saved_pb;

  logic             produces;
  logic             can_load;
  logic             load;
  logic [WordW-1:0] word;
  logic [ByteW-1:0] hi;
  logic [WordW-1:0] wy;
  logic [AddrW-1:0] iref;
  logic             reply_dok;

  logic             kind_next;
  logic [AddrW-1:0] fetch_address_next;
  logic [AddrW-1:0] operand_value_next;
  logic             operand_valid_next;
  logic [RefW-1:0]  direct_target_next;
  logic             direct_valid_next;
  logic [AddrW-1:0] indirect_target_next;
  logic             indirect_valid_next;

  // a reply with no fetch outstanding is dropped without a result
  assign produces = (head.func == FUNC_DECODE) || pending;
  assign can_load = !out_valid || !out_stall;
  assign pop      = !empty && (can_load || !produces);
  assign load     = pop && produces;

  // indirect reference from the fetched pointer
  assign word      = head.rdata[15:0];
  assign hi        = head.rdata[23:16];
  assign wy        = word + saved_y;
  assign reply_dok = (pending_mode != MODE_SR_S_IND_Y);

  always_comb begin
    case (pending_mode) inside
      MODE_DP_IND, MODE_DP_X_IND:      iref = {saved_db, word};
      MODE_DP_IND_Y, MODE_SR_S_IND_Y:  iref = {saved_db, wy};
      MODE_DP_LIND, MODE_ABS_LIND:     iref = {hi, word};
      MODE_DP_LIND_Y:                  iref = {hi, wy};
      default:                         iref = {saved_pb, word};
    endcase
  end

  // result selection
  always_comb begin
    kind_next            = KIND_RESULT;
    fetch_address_next   = '0;
    operand_value_next   = '0;
    operand_valid_next   = 1'b0;
    direct_target_next   = '0;
    direct_valid_next    = 1'b0;
    indirect_target_next = '0;
    indirect_valid_next  = 1'b0;
    if (head.func == FUNC_REPLY) begin
      operand_value_next   = saved_operand;
      operand_valid_next   = 1'b1;
      direct_target_next   = reply_dok ? saved_reference : '0;
      direct_valid_next    = reply_dok;
      indirect_target_next = iref;
      indirect_valid_next  = 1'b1;
    end else if (head.indirect) begin
      kind_next          = KIND_FETCH;
      fetch_address_next = head.dref[AddrW-1:0];
    end else begin
      operand_value_next = head.opok ? head.opv : '0;
      operand_valid_next = head.opok;
      direct_target_next = head.dok ? head.dref : '0;
      direct_valid_next  = head.dok;
    end
  end

  // pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (pop) begin
      pending <= (head.func == FUNC_DECODE) && head.indirect;
    end
  end

  // saved context of an outstanding fetch
  always_ff @(posedge clk) begin
    if (pop && (head.func == FUNC_DECODE) && head.indirect) begin
      pending_mode    <= head.mode;
      saved_operand   <= head.opv;
      saved_reference <= head.dref;
      saved_y         <= head.y;
      saved_db        <= head.db;
      saved_pb        <= head.pb;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      kind            <= kind_next;
      fetch_address   <= fetch_address_next;
      operand_value   <= operand_value_next;
      operand_valid   <= operand_valid_next;
      direct_target   <= direct_target_next;
      direct_valid    <= direct_valid_next;
      indirect_target <= indirect_target_next;
      indirect_valid  <= indirect_valid_next;
    end
  end

  // checks
  a_fetch_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_FETCH) |->
      !operand_valid && !direct_valid && !indirect_valid)
    else $error("fetch request carries valid result fields");

  a_indirect_is_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && indirect_valid |-> (kind == KIND_RESULT))
    else $error("indirect reference outside a decoded result");

  a_fetch_sets_pending: assert property (@(posedge clk) disable iff (rst)
    load && (head.func == FUNC_DECODE) && head.indirect |=> pending && out_valid)
    else $error("fetch request issued without pending context");

  a_reply_clears_pending: assert property (@(posedge clk) disable iff (rst)
    pop && (head.func == FUNC_REPLY) |=> !pending)
    else $error("pending context kept after reply");

endmodule

`default_nettype wire

// ----- src/cpu65816_operand_reference_decode.sv -----
// Top level of the 65816 operand and reference decoder.
// Instantiates oprd_front, oprd_queue and oprd_back; depends on oprd_pkg.
//
//   channel  handshake             payload
//   input    in_valid / in_stall   func, mode, pc, operand_bytes, flags, regs, read_data
//   output   out_valid / out_stall kind, fetch_address, operand/direct/indirect fields
//
// One transaction per cycle sustained unless out_stall holds results back; a result
// is written to the queue, then loaded into the output register and offered there.
// The path is set by the front-end three-input adders feeding the queue.
// Reset clears the queue, the pending-fetch flag and the output valid.
// in_stall rises only when the two-entry queue is full; a reply with no fetch
// outstanding is consumed without a result even while the output is stalled.
`default_nettype none

module cpu65816_operand_reference_decode (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              func,
  input  wire logic [oprd_pkg::ModeW-1:0]        mode,
  input  wire logic [oprd_pkg::AddrW-1:0]        pc,
  input  wire logic [oprd_pkg::AddrW-1:0]        operand_bytes,
  input  wire logic [oprd_pkg::ByteW-1:0]        status_flags,
  input  wire logic [oprd_pkg::WordW-1:0]        direct_page,
  input  wire logic [oprd_pkg::WordW-1:0]        index_x,
  input  wire logic [oprd_pkg::WordW-1:0]        index_y,
  input  wire logic [oprd_pkg::WordW-1:0]        stack_ptr,
  input  wire logic [oprd_pkg::ByteW-1:0]        data_bank,
  input  wire logic [oprd_pkg::ByteW-1:0]        program_bank,
  input  wire logic [oprd_pkg::AddrW-1:0]        read_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   kind,
  output logic [oprd_pkg::AddrW-1:0]             fetch_address,
  output logic [oprd_pkg::AddrW-1:0]             operand_value,
  output logic                                   operand_valid,
  output logic signed [oprd_pkg::RefW-1:0]       direct_target,
  output logic                                   direct_valid,
  output logic [oprd_pkg::AddrW-1:0]             indirect_target,
  output logic                                   indirect_valid
);
  import oprd_pkg::*;

  oprd_entry_t     front_entry;
  oprd_entry_t     head;
  logic            q_empty;
  logic            q_full;
  logic            q_pop;
  logic [RefW-1:0] dref_out;

  assign in_stall      = q_full;
  assign direct_target = dref_out;

  // classify the incoming transaction
  oprd_front u_front (
    .func          (func),
    .mode          (mode),
    .pc            (pc),
    .operand_bytes (operand_bytes),
    .status_flags  (status_flags),
    .direct_page   (direct_page),
    .index_x       (index_x),
    .index_y       (index_y),
    .stack_ptr     (stack_ptr),
    .data_bank     (data_bank),
    .program_bank  (program_bank),
    .read_data     (read_data),
    .entry         (front_entry)
  );

  // decoupling queue
  oprd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid),
    .push_entry (front_entry),
    .pop        (q_pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // pending context and result register
  oprd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .empty           (q_empty),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .fetch_address   (fetch_address),
    .operand_value   (operand_value),
    .operand_valid   (operand_valid),
    .direct_target   (dref_out),
    .direct_valid    (direct_valid),
    .indirect_target (indirect_target),
    .indirect_valid  (indirect_valid)
  );

endmodule

`default_nettype wire

// ----- test/cpu65816_operand_reference_decode_test.sv -----
// Self-checking testbench for the 65816 operand and reference decoder.
// Drives directed and random instructions and replies, predicts every result.
// Depends on oprd_pkg and cpu65816_operand_reference_decode.

module cpu65816_operand_reference_decode_test;
  import oprd_pkg::*;

  localparam logic [ModeW-1:0] MODE_SPARE = 5'd28;
  localparam logic [ModeW-1:0] MODE_TOP   = 5'd31;
  localparam int RandResults = 1600;
  localparam int QuietLimit  = 1000;
  localparam int HoldCycles  = 40;
  localparam int HoldAfter   = 200;

  typedef struct packed {
    logic             func;
    logic [ModeW-1:0] mode;
    logic [AddrW-1:0] pc;
    logic [AddrW-1:0] ob;
    logic [ByteW-1:0] p;
    logic [WordW-1:0] d;
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
    logic [WordW-1:0] s;
    logic [ByteW-1:0] db;
    logic [ByteW-1:0] pb;
    logic [AddrW-1:0] rd;
  } instr_item_t;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] fetch;
    logic [AddrW-1:0] opv;
    logic             opok;
    logic [RefW-1:0]  dref;
    logic             dok;
    logic [AddrW-1:0] iref;
    logic             iok;
  } decode_result_t;

  // directed row: result typed in by hand when typed is set
  typedef struct packed {
    instr_item_t    item;
    logic           typed;
    logic           typed_has;
    decode_result_t typed_res;
  } instr_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = FUNC_DECODE;
  logic [ModeW-1:0] mode = MODE_IMPLIED;
  logic [AddrW-1:0] pc = '0;
  logic [AddrW-1:0] operand_bytes = '0;
  logic [ByteW-1:0] status_flags = '0;
  logic [WordW-1:0] direct_page = '0;
  logic [WordW-1:0] index_x = '0;
  logic [WordW-1:0] index_y = '0;
  logic [WordW-1:0] stack_ptr = '0;
  logic [ByteW-1:0] data_bank = '0;
  logic [ByteW-1:0] program_bank = '0;
  logic [AddrW-1:0] read_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic kind;
  logic [AddrW-1:0] fetch_address;
  logic [AddrW-1:0] operand_value;
  logic operand_valid;
  logic signed [RefW-1:0] direct_target;
  logic direct_valid;
  logic [AddrW-1:0] indirect_target;
  logic indirect_valid;

  cpu65816_operand_reference_decode u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .mode(mode), .pc(pc), .operand_bytes(operand_bytes),
    .status_flags(status_flags), .direct_page(direct_page),
    .index_x(index_x), .index_y(index_y), .stack_ptr(stack_ptr),
    .data_bank(data_bank), .program_bank(program_bank), .read_data(read_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .fetch_address(fetch_address),
    .operand_value(operand_value), .operand_valid(operand_valid),
    .direct_target(direct_target), .direct_valid(direct_valid),
    .indirect_target(indirect_target), .indirect_valid(indirect_valid)
  );

  // predictor state: the outstanding pointer fetch
  logic             pend = 1'b0;
  logic [ModeW-1:0] pend_mode = '0;
  logic [AddrW-1:0] saved_opv = '0;
  logic [RefW-1:0]  saved_ref = '0;
  logic [WordW-1:0] saved_y = '0;
  logic [ByteW-1:0] saved_db = '0;
  logic [ByteW-1:0] saved_pb = '0;

  decode_result_t due_results[$];
  instr_row_t     dir_rows[$];
  int mismatches = 0;
  int results_seen = 0;
  int tx_idle_pct = 16;
  int rx_idle_pct = 53;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // work out the result of one transaction, updating the fetch context
  function automatic bit decode_reference(input instr_item_t it, output decode_result_t res);
    logic [31:0] addr, b0, w16, ob, d, x, y, s, db, pb, opv, dsum;
    logic [WordW-1:0] word, wy;
    logic [ByteW-1:0] hi;
    logic [AddrW-1:0] iref;
    bit opok, dok, ind;
    res = '0;
    if (it.func == FUNC_REPLY) begin
      if (!pend) return 1'b0;
      word = it.rd[15:0];
      hi = it.rd[23:16];
      wy = word + saved_y;
      case (pend_mode)
        MODE_DP_IND, MODE_DP_X_IND:      iref = {saved_db, word};
        MODE_DP_IND_Y, MODE_SR_S_IND_Y:  iref = {saved_db, wy};
        MODE_DP_LIND, MODE_ABS_LIND:     iref = {hi, word};
        MODE_DP_LIND_Y:                  iref = {hi, wy};
        default:                         iref = {saved_pb, word};
      endcase
      pend = 1'b0;
      res.kind = KIND_RESULT;
      res.opv = saved_opv;
      res.opok = 1'b1;
      // stack relative indirect keeps its stack address to itself
      if (pend_mode != MODE_SR_S_IND_Y) begin
        res.dref = saved_ref;
        res.dok = 1'b1;
      end
      res.iref = iref;
      res.iok = 1'b1;
      return 1'b1;
    end

    addr = 32'(it.pc[15:0]);
    ob = 32'(it.ob);
    b0 = 32'(it.ob[7:0]);
    w16 = 32'(it.ob[15:0]);
    d = 32'(it.d);
    x = 32'(it.x);
    y = 32'(it.y);
    s = 32'(it.s);
    db = 32'(it.db);
    pb = 32'(it.pb);
    opv = '0;
    dsum = '0;
    opok = 1'b1;
    dok = 1'b0;
    ind = 1'b0;
    pend = 1'b0;
    case (it.mode)
      MODE_IMM_M: opv = it.p[5] ? b0 : w16;
      MODE_IMM_X: opv = it.p[4] ? b0 : w16;
      MODE_IMM8, MODE_SR_S: opv = b0;
      MODE_REL: begin
        opv = b0;
        dsum = addr + 32'd2 - (b0[7] ? 32'h100 : 32'h0) + b0;
        dok = 1'b1;
      end
      MODE_REL_LONG: begin
        opv = w16;
        dsum = addr + 32'd3 - (w16[15] ? 32'h10000 : 32'h0) + w16;
        dok = 1'b1;
      end
      MODE_DP, MODE_PEI: begin
        opv = b0; dsum = b0 + d; dok = 1'b1;
      end
      MODE_DP_X: begin
        opv = b0; dsum = b0 + d + x; dok = 1'b1;
      end
      MODE_DP_Y: begin
        opv = b0; dsum = b0 + d + y; dok = 1'b1;
      end
      MODE_DP_IND, MODE_DP_IND_Y, MODE_DP_LIND, MODE_DP_LIND_Y: begin
        opv = b0; dsum = b0 + d; dok = 1'b1; ind = 1'b1;
      end
      MODE_DP_X_IND: begin
        opv = b0; dsum = b0 + d + x; dok = 1'b1; ind = 1'b1;
      end
      MODE_ABS: begin
        opv = w16; dsum = (db << 16) | w16; dok = 1'b1;
      end
      MODE_ABS_X: begin
        opv = w16; dsum = ((db << 16) + w16 + x) & 32'hFFFFFF; dok = 1'b1;
      end
      MODE_ABS_Y: begin
        opv = w16; dsum = ((db << 16) + w16 + y) & 32'hFFFFFF; dok = 1'b1;
      end
      MODE_LONG: begin
        opv = ob; dsum = ob; dok = 1'b1;
      end
      MODE_LONG_X: begin
        opv = ob; dsum = (ob & 32'hFF0000) | ((w16 + x) & 32'hFFFF); dok = 1'b1;
      end
      MODE_SR_S_IND_Y: begin
        opv = b0; dsum = b0 + s; ind = 1'b1;
      end
      MODE_ABS_IND, MODE_ABS_LIND: begin
        opv = w16; dsum = w16; dok = 1'b1; ind = 1'b1;
      end
      MODE_ABS_X_IND: begin
        opv = w16; dsum = (pb << 16) | ((w16 + x) & 32'hFFFF); dok = 1'b1; ind = 1'b1;
      end
      MODE_BLOCK, MODE_PEA: opv = w16;
      default: opok = 1'b0;
    endcase

    // indirect modes ask for the pointer first and keep the context
    if (ind) begin
      pend = 1'b1;
      pend_mode = it.mode;
      saved_opv = opv[AddrW-1:0];
      saved_ref = dsum[RefW-1:0];
      saved_y = it.y;
      saved_db = it.db;
      saved_pb = it.pb;
      res.kind = KIND_FETCH;
      res.fetch = dsum[AddrW-1:0];
      return 1'b1;
    end
    res.kind = KIND_RESULT;
    if (opok) begin
      res.opv = opv[AddrW-1:0];
      res.opok = 1'b1;
    end
    if (dok) begin
      res.dref = dsum[RefW-1:0];
      res.dok = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic instr_item_t mk(input logic f, input logic [ModeW-1:0] m,
                                     input logic [AddrW-1:0] a, input logic [AddrW-1:0] ob,
                                     input logic [ByteW-1:0] p, input logic [WordW-1:0] d,
                                     input logic [WordW-1:0] x, input logic [WordW-1:0] y,
                                     input logic [WordW-1:0] s, input logic [ByteW-1:0] db,
                                     input logic [ByteW-1:0] pb, input logic [AddrW-1:0] rd);
    instr_item_t it;
    it.func = f; it.mode = m; it.pc = a; it.ob = ob; it.p = p;
    it.d = d; it.x = x; it.y = y; it.s = s; it.db = db; it.pb = pb; it.rd = rd;
    return it;
  endfunction

  // field value biased towards all zeros and all ones
  function automatic logic [31:0] pick(input int w);
    logic [31:0] mask;
    mask = (32'd1 << w) - 32'd1;
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic instr_item_t random_item();
    instr_item_t it;
    it.func = FUNC_DECODE;
    it.mode = ModeW'($urandom_range(0, 31));
    it.pc = AddrW'(pick(AddrW));
    it.ob = AddrW'(pick(AddrW));
    it.p = ByteW'(pick(ByteW));
    it.d = WordW'(pick(WordW));
    it.x = WordW'(pick(WordW));
    it.y = WordW'(pick(WordW));
    it.s = WordW'(pick(WordW));
    it.db = ByteW'(pick(ByteW));
    it.pb = ByteW'(pick(ByteW));
    it.rd = AddrW'(pick(AddrW));
    return it;
  endfunction

  task automatic add_row(input instr_item_t it, input logic typed, input logic has,
                         input decode_result_t r);
    instr_row_t row;
    row.item = it;
    row.typed = typed;
    row.typed_has = has;
    row.typed_res = r;
    dir_rows.push_back(row);
  endtask

  // offer one transaction, wait for it to be taken, then record what it should give
  task automatic push_item(input instr_item_t it, input logic typed, input logic typed_has,
                           input decode_result_t typed_res, output bit produced);
    decode_result_t res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    func <= it.func;
    mode <= it.mode;
    pc <= it.pc;
    operand_bytes <= it.ob;
    status_flags <= it.p;
    direct_page <= it.d;
    index_x <= it.x;
    index_y <= it.y;
    stack_ptr <= it.s;
    data_bank <= it.db;
    program_bank <= it.pb;
    read_data <= it.rd;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    produced = decode_reference(it, res);
    if (typed) begin
      produced = typed_has;
      if (typed_has) due_results.push_back(typed_res);
    end else if (produced) begin
      due_results.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result side: check each transaction, then choose the stall for the next cycle
  always @(posedge clk) begin
    decode_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0h", $time, kind);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind));
        check_field("fetch_address", 32'(want.fetch), 32'(fetch_address));
        check_field("operand_value", 32'(want.opv), 32'(operand_value));
        check_field("operand_valid", 32'(want.opok), 32'(operand_valid));
        check_field("direct_target", 32'(want.dref), 32'(direct_target[RefW-1:0]));
        check_field("direct_valid", 32'(want.dok), 32'(direct_valid));
        check_field("indirect_target", 32'(want.iref), 32'(indirect_target));
        check_field("indirect_valid", 32'(want.iok), 32'(indirect_valid));
      end
    end
    // one long hold-off so the queue fills and the input backs up
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen == HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QuietLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    decode_result_t bare, r;
    instr_item_t it;
    bit got;
    int produced_total;

    bare = '0;
    bare.kind = KIND_RESULT;

    // reply with nothing outstanding, then modes with nothing valid
    add_row(mk(FUNC_REPLY, MODE_IMPLIED, 24'h0, 24'h0, 8'h0, 16'h0, 16'h0, 16'h0,
               16'h0, 8'h0, 8'h0, 24'hFFFFFF), 1'b1, 1'b0, '0);
    add_row(mk(FUNC_DECODE, MODE_IMPLIED, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 16'hFFFF,
               16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 24'hFFFFFF), 1'b1, 1'b1, bare);
    add_row(mk(FUNC_DECODE, MODE_TOP, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 16'hFFFF,
               16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 24'hFFFFFF), 1'b1, 1'b1, bare);
    add_row(mk(FUNC_DECODE, MODE_SPARE, 24'h0, 24'h0, 8'h0, 16'h0, 16'h0, 16'h0,
               16'h0, 8'h0, 8'h0, 24'h0), 1'b1, 1'b1, bare);
    add_row(mk(FUNC_DECODE, MODE_ACC, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 16'hFFFF,
               16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 24'hFFFFFF), 1'b1, 1'b1, bare);
    // immediate widths
    r = bare;
    r.opv = 24'hFF;
    r.opok = 1'b1;
    add_row(mk(FUNC_DECODE, MODE_IMM_M, 24'h0, 24'hFFFFFF, 8'h20, 16'h0, 16'h0, 16'h0,
               16'h0, 8'h0, 8'h0, 24'h0), 1'b1, 1'b1, r);
    r.opv = 24'hFFFF;
    add_row(mk(FUNC_DECODE, MODE_IMM_M, 24'h0, 24'hFFFFFF, 8'h00, 16'h0, 16'h0, 16'h0,
               16'h0, 8'h0, 8'h0, 24'h0), 1'b1, 1'b1, r);
    add_row(mk(FUNC_DECODE, MODE_IMM_X, 24'h0, 24'hFFFFFF, 8'h10, 16'h0, 16'h0, 16'h0,
               16'h0, 8'h0, 8'h0, 24'h0), 1'b0, 1'b0, '0);
    add_row(mk(FUNC_DECODE, MODE_IMM_X, 24'h0, 24'h123456, 8'hEF, 16'h0, 16'h0, 16'h0,
               16'h0, 8'h0, 8'h0, 24'h0), 1'b0, 1'b0, '0);
    // branch below zero and above the bank
    add_row(mk(FUNC_DECODE, MODE_REL, 24'h0, 24'h000080, 8'h0, 16'h0, 16'h0, 16'h0,
               16'h0, 8'h0, 8'h0, 24'h0), 1'b0, 1'b0, '0);
    add_row(mk(FUNC_DECODE, MODE_REL_LONG, 24'hFFFFFF, 24'h007FFF, 8'h0, 16'h0, 16'h0,
               16'h0, 16'h0, 8'h0, 8'h0, 24'h0), 1'b0, 1'b0, '0);
    // largest sums
    add_row(mk(FUNC_DECODE, MODE_DP_X, 24'h0, 24'h0000FF, 8'h0, 16'hFFFF, 16'hFFFF,
               16'h0, 16'h0, 8'h0, 8'h0, 24'h0), 1'b0, 1'b0, '0);
    add_row(mk(FUNC_DECODE, MODE_ABS_X, 24'h0, 24'h00FFFF, 8'h0, 16'h0, 16'hFFFF,
               16'h0, 16'h0, 8'hFF, 8'h0, 24'h0), 1'b0, 1'b0, '0);
    add_row(mk(FUNC_DECODE, MODE_LONG_X, 24'h0, 24'hFFFFFF, 8'h0, 16'h0, 16'hFFFF,
               16'h0, 16'h0, 8'h0, 8'h0, 24'h0), 1'b0, 1'b0, '0);
    add_row(mk(FUNC_DECODE, MODE_LONG, 24'h0, 24'hFFFFFF, 8'h0, 16'h0, 16'h0,
               16'h0, 16'h0, 8'h0, 8'h0, 24'h0), 1'b0, 1'b0, '0);
    // pointer fetch and its reply
    add_row(mk(FUNC_DECODE, MODE_DP_IND, 24'h0, 24'h000010, 8'h0, 16'h1200, 16'h0,
               16'h0, 16'h0, 8'h7E, 8'h0, 24'h0), 1'b0, 1'b0, '0);
    add_row(mk(FUNC_REPLY, MODE_IMPLIED, 24'h0, 24'h0, 8'h0, 16'h0, 16'h0, 16'h0,
               16'h0, 8'h0, 8'h0, 24'h00ABCD), 1'b0, 1'b0, '0);
    // stack relative indirect, no direct reference reported
    add_row(mk(FUNC_DECODE, MODE_SR_S_IND_Y, 24'h0, 24'h0000FF, 8'h0, 16'h0, 16'h0,
               16'hFFFF, 16'hFFFF, 8'hFF, 8'h0, 24'h0), 1'b0, 1'b0, '0);
    add_row(mk(FUNC_REPLY, MODE_IMPLIED, 24'h0, 24'h0, 8'h0, 16'h0, 16'h0, 16'h0,
               16'h0, 8'h0, 8'h0, 24'hFFFFFF), 1'b0, 1'b0, '0);
    // new decode drops the outstanding fetch, its reply is then ignored
    add_row(mk(FUNC_DECODE, MODE_DP_LIND_Y, 24'h0, 24'h000044, 8'h0, 16'h0100, 16'h0,
               16'h8000, 16'h0, 8'h0, 8'h0, 24'h0), 1'b0, 1'b0, '0);
    add_row(mk(FUNC_DECODE, MODE_DP, 24'h0, 24'h000044, 8'h0, 16'h0100, 16'h0,
               16'h0, 16'h0, 8'h0, 8'h0, 24'h0), 1'b0, 1'b0, '0);
    add_row(mk(FUNC_REPLY, MODE_IMPLIED, 24'h0, 24'h0, 8'h0, 16'h0, 16'h0, 16'h0,
               16'h0, 8'h0, 8'h0, 24'h123456), 1'b1, 1'b0, '0);
    // jump through pointer tables
    add_row(mk(FUNC_DECODE, MODE_ABS_X_IND, 24'h0, 24'h00FFFF, 8'h0, 16'h0, 16'h0002,
               16'h0, 16'h0, 8'h0, 8'h80, 24'h0), 1'b0, 1'b0, '0);
    add_row(mk(FUNC_REPLY, MODE_IMPLIED, 24'h0, 24'h0, 8'h0, 16'h0, 16'h0, 16'h0,
               16'h0, 8'h0, 8'h0, 24'hFF8000), 1'b0, 1'b0, '0);
    add_row(mk(FUNC_DECODE, MODE_ABS_LIND, 24'h0, 24'h00FFFF, 8'h0, 16'h0, 16'h0,
               16'h0, 16'h0, 8'h0, 8'h0, 24'h0), 1'b0, 1'b0, '0);
    add_row(mk(FUNC_REPLY, MODE_IMPLIED, 24'h0, 24'h0, 8'h0, 16'h0, 16'h0, 16'h0,
               16'h0, 8'h0, 8'h0, 24'hFFFFFF), 1'b0, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].typed_has,
                dir_rows[i].typed_res, got);

    // random instructions, most indirect ones answered by a reply
    produced_total = 0;
    while (produced_total < RandResults) begin
      if (produced_total < RandResults / 3) begin
        tx_idle_pct = 16;
        rx_idle_pct = 53;
      end else if (produced_total < 2 * RandResults / 3) begin
        tx_idle_pct = 53;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      it = random_item();
      if ($urandom_range(0, 99) < 6) it.func = FUNC_REPLY;
      push_item(it, 1'b0, 1'b0, '0, got);
      produced_total += int'(got);
      if (it.func == FUNC_DECODE && pend && $urandom_range(0, 99) < 85) begin
        it = random_item();
        it.func = FUNC_REPLY;
        push_item(it, 1'b0, 1'b0, '0, got);
        produced_total += int'(got);
      end
    end
    in_valid <= 1'b0;

    // drain, then wait on for anything stray
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/oprd_pkg.sv
src/oprd_front.sv
src/oprd_queue.sv
src/oprd_back.sv
src/cpu65816_operand_reference_decode.sv
test/cpu65816_operand_reference_decode_test.sv
